@@ sv/tea_pkg.sv @@
// Shared types, constants and the TEA round function for the TEA block cipher unit.
// No dependencies; every other file of the block imports this package.
package tea_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BLOCK_W     = 2 * WORD_W;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned ROUNDS_DEF  = 32;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0   = 3'd0,
		REG_KEY1   = 3'd1,
		REG_KEY2   = 3'd2,
		REG_KEY3   = 3'd3,
		REG_IV     = 3'd4,
		REG_MODE   = 3'd5,
		REG_DECRYPT = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CTR = 2'd2
	} mode_t;

	// What the back engine has to do with one block
	typedef enum logic [2:0] {
		JOB_ECB_ENC,
		JOB_ECB_DEC,
		JOB_CBC_ENC,
		JOB_CBC_DEC,
		JOB_CTR
	} job_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROUND,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [WORD_W-1:0]  key0;
		logic [WORD_W-1:0]  key1;
		logic [WORD_W-1:0]  key2;
		logic [WORD_W-1:0]  key3;
		logic [BLOCK_W-1:0] iv;
		logic [1:0]         mode;
		logic               decrypt;
	} tea_cfg_t;

	// Queue entry; the first word of a block sits in the low half
	typedef struct packed {
		logic [BLOCK_W-1:0] data;
		logic [BLOCK_W-1:0] cipher_in;
		job_kind_t          kind;
		logic               start;
	} tea_job_t;

	// One half of a TEA round
	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] v,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
	endfunction

endpackage

@@ sv/tea_if.sv @@
// Channel interfaces of the TEA block cipher unit: input blocks, result blocks and
// configuration writes. Depends on tea_pkg.
interface tea_in_if import tea_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word_first;
	logic [WORD_W-1:0] word_second;
	logic              message_start;

	modport source(output valid, word_first, word_second, message_start, input ready);
	modport sink(input valid, word_first, word_second, message_start, output ready);
endinterface

interface tea_out_if import tea_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result_first;
	logic [WORD_W-1:0] result_second;

	modport source(output valid, result_first, result_second, input ready);
	modport sink(input valid, result_first, result_second, output ready);
endinterface

interface tea_cfg_if import tea_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BLOCK_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/tea_cipher_ecb_cbc_ctr_unit.sv @@
// TEA block cipher unit (64-bit block, 128-bit key) with ECB, CBC and CTR chaining.
// Each input transfer carries one block; one result block leaves per input block, in order.
// The round engine performs one TEA round per clock and sets the sustained rate.
// A two-entry job queue lets the input side take further blocks while a block is in
// its rounds, and the output register lets the engine finish while a result waits.
// Configuration writes are always ready and should be made only while the unit is idle.
module tea_cipher_ecb_cbc_ctr_unit import tea_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUNDS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	tea_cfg_if.sink  cfg,
	tea_in_if.sink   data_in,
	tea_out_if.source data_out
);

	tea_cfg_t cfg_q;
	tea_job_t push_job;
	tea_job_t head;
	logic     push;
	logic     pop;
	logic     queue_full;
	logic     head_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KEY0:    cfg_q.key0    <= cfg.data[WORD_W-1:0];
				REG_KEY1:    cfg_q.key1    <= cfg.data[WORD_W-1:0];
				REG_KEY2:    cfg_q.key2    <= cfg.data[WORD_W-1:0];
				REG_KEY3:    cfg_q.key3    <= cfg.data[WORD_W-1:0];
				REG_IV:      cfg_q.iv      <= cfg.data;
				REG_MODE:    cfg_q.mode    <= cfg.data[1:0];
				REG_DECRYPT: cfg_q.decrypt <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	tea_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_q),
		.data_in    (data_in),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	tea_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid)
	);

	tea_back #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.data_out   (data_out)
	);

endmodule

@@ sv/tea_front.sv @@
// Front end of the TEA unit: accepts input blocks, keeps the CTR block counter and
// classifies each block into a job for the queue. Depends on tea_pkg and tea_if.
module tea_front import tea_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  tea_cfg_t        cfg_regs,
	tea_in_if.sink          data_in,
	input  logic            queue_full,
	output logic            push,
	output tea_job_t        job
);

	logic [BLOCK_W-1:0] count_q;
	logic [BLOCK_W-1:0] count_eff;

	assign data_in.ready = !queue_full;
	assign push          = data_in.valid && !queue_full;

	// A message start restarts the counter before this block uses it.
	assign count_eff = data_in.message_start ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_eff + BLOCK_W'(1);
		end
	end

	always_comb begin
		job.data  = {data_in.word_second, data_in.word_first};
		job.start = data_in.message_start;
		job.cipher_in = job.data;
		unique case (cfg_regs.mode)
			MODE_CBC: begin
				job.kind = cfg_regs.decrypt ? JOB_CBC_DEC : JOB_CBC_ENC;
			end
			MODE_CTR: begin
				job.kind = JOB_CTR;
				// Counter high half goes onto the first IV word, low half onto the second.
				job.cipher_in = {
					cfg_regs.iv[BLOCK_W-1:WORD_W] + count_eff[WORD_W-1:0],
					cfg_regs.iv[WORD_W-1:0] + count_eff[BLOCK_W-1:WORD_W]
				};
			end
			default: begin
				job.kind = cfg_regs.decrypt ? JOB_ECB_DEC : JOB_ECB_ENC;
			end
		endcase
	end

endmodule

@@ sv/tea_queue.sv @@
// Short job queue between the TEA front end and the round engine.
// Depends on tea_pkg.
module tea_queue import tea_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tea_job_t push_job,
	output logic     full,
	input  logic     pop,
	output tea_job_t head,
	output logic     not_empty
);

	tea_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("job queue holds more entries than it has slots");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("job queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("job queue lost a pushed entry");
`endif

endmodule

@@ sv/tea_back.sv @@
// Round engine of the TEA unit: takes jobs from the queue, applies CBC chaining and the CTR
// mask, runs one TEA round per cycle and holds the result in an output register.
// Depends on tea_pkg and tea_if.
module tea_back import tea_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUNDS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tea_cfg_t cfg_regs,
	input  tea_job_t head,
	input  logic     head_valid,
	output logic     pop,
	tea_out_if.source data_out
);

	localparam int unsigned RND_W = $clog2(ROUND_COUNT + 1);
	localparam logic [WORD_W-1:0] SUM_DEC =
		WORD_W'(64'(TEA_DELTA) * 64'(ROUND_COUNT));

	back_state_t          state_q, state_d;
	logic [RND_W-1:0]     rnd_q;
	logic [WORD_W-1:0]    x_q, y_q, s_q;
	logic                 dec_q;
	logic                 cbc_enc_q;
	logic [BLOCK_W-1:0]   mask_q;
	logic [BLOCK_W-1:0]   chain_q;
	logic                 out_valid_q;
	logic [BLOCK_W-1:0]   out_data_q;

	logic                 out_free;
	logic                 done_fire;
	logic                 last_round;
	logic [BLOCK_W-1:0]   result;
	logic [BLOCK_W-1:0]   chain_cur;
	logic [BLOCK_W-1:0]   chain_eff;
	logic [BLOCK_W-1:0]   load_block;
	logic [WORD_W-1:0]    x_enc, y_enc, x_dec, y_dec;

	assign out_free   = !out_valid_q || data_out.ready;
	assign last_round = (rnd_q == RND_W'(ROUND_COUNT - 1));
	assign result     = {y_q, x_q} ^ mask_q;

	// A CBC encryption finishing in this cycle hands its result straight to the next job.
	assign chain_cur = (done_fire && cbc_enc_q) ? result : chain_q;
	assign chain_eff = head.start ? cfg_regs.iv : chain_cur;
	assign load_block = (head.kind == JOB_CBC_ENC) ? (head.data ^ chain_eff) : head.cipher_in;

	// Encryption round, then decryption round, each on the current sum.
	assign x_enc = x_q + tea_mix(y_q, s_q, cfg_regs.key0, cfg_regs.key1);
	assign y_enc = y_q + tea_mix(x_enc, s_q, cfg_regs.key2, cfg_regs.key3);
	assign y_dec = y_q - tea_mix(x_q, s_q, cfg_regs.key2, cfg_regs.key3);
	assign x_dec = x_q - tea_mix(y_dec, s_q, cfg_regs.key0, cfg_regs.key1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid) state_d = BK_ROUND;
			end
			BK_ROUND: begin
				if (last_round) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) state_d = head_valid ? BK_ROUND : BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = head_valid;
			end
			BK_DONE: begin
				done_fire = out_free;
				pop       = out_free && head_valid;
			end
			default: begin
				pop       = 1'b0;
				done_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rnd_q       <= '0;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				rnd_q   <= '0;
				chain_q <= (head.kind == JOB_CBC_DEC) ? head.data : chain_eff;
			end else begin
				if (state_q == BK_ROUND) begin
					rnd_q <= rnd_q + RND_W'(1);
				end
				if (done_fire && cbc_enc_q) begin
					chain_q <= result;
				end
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (data_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q       <= load_block[WORD_W-1:0];
			y_q       <= load_block[BLOCK_W-1:WORD_W];
			dec_q     <= (head.kind == JOB_ECB_DEC) || (head.kind == JOB_CBC_DEC);
			s_q       <= ((head.kind == JOB_ECB_DEC) || (head.kind == JOB_CBC_DEC)) ?
			             SUM_DEC : TEA_DELTA;
			cbc_enc_q <= (head.kind == JOB_CBC_ENC);
			case (head.kind)
				JOB_CBC_DEC: mask_q <= chain_eff;
				JOB_CTR:     mask_q <= head.data;
				default:     mask_q <= '0;
			endcase
		end else if (state_q == BK_ROUND) begin
			if (dec_q) begin
				x_q <= x_dec;
				y_q <= y_dec;
				s_q <= s_q - TEA_DELTA;
			end else begin
				x_q <= x_enc;
				y_q <= y_enc;
				s_q <= s_q + TEA_DELTA;
			end
		end
		if (done_fire) begin
			out_data_q <= result;
		end
	end

	assign data_out.valid         = out_valid_q;
	assign data_out.result_first  = out_data_q[WORD_W-1:0];
	assign data_out.result_second = out_data_q[BLOCK_W-1:WORD_W];

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_ROUND) |-> (rnd_q <= RND_W'(ROUND_COUNT - 1)))
		else $error("round counter ran past the last round");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> (state_q != BK_ROUND))
		else $error("job taken while rounds are still running");
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> (state_q == BK_ROUND))
		else $error("taken job did not start its rounds");
	assert property (@(posedge clk) disable iff (!arst_n) done_fire |=> out_valid_q)
		else $error("finished block did not reach the output register");
`endif

endmodule

@@ test/tb_tea_cipher_ecb_cbc_ctr_unit.sv @@
// Self-checking testbench for the TEA block cipher unit in ECB, CBC and CTR modes.
// A behavioural predictor checks every result block; needs tea_pkg, the channel
// interfaces and the unit itself.
`timescale 1ns / 100ps

module tb_tea_cipher_ecb_cbc_ctr_unit;
	import tea_pkg::*;

	localparam int unsigned ROUND_COUNT  = ROUNDS_DEF;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned SETTLE       = 4;
	localparam int unsigned DRAIN_CYCLES = 2 * ROUND_COUNT;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] second;
		logic [WORD_W-1:0] first;
	} tea_block_t;

	logic clk;
	logic arst_n;

	tea_cfg_if cfg_bus();
	tea_in_if  in_bus();
	tea_out_if out_bus();

	tea_cipher_ecb_cbc_ctr_unit #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.data_in (in_bus),
		.data_out(out_bus)
	);

	// Predictor copy of the registers and the chaining state
	logic [WORD_W-1:0]  key_words [4];
	logic [BLOCK_W-1:0] init_vec;
	logic [1:0]         chain_sel;
	logic               decrypt_on;
	logic [BLOCK_W-1:0] chain_block;
	logic [BLOCK_W-1:0] block_index;

	tea_block_t expected_blocks[$];
	int unsigned fail_count;
	int unsigned stall_cycles;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] round_mix(
		input logic [WORD_W-1:0] v,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
	endfunction

	function automatic tea_block_t tea_encipher(input tea_block_t blk);
		logic [WORD_W-1:0] x, y, s;
		x = blk.first;
		y = blk.second;
		s = '0;
		for (int r = 0; r < ROUND_COUNT; r++) begin
			s += TEA_DELTA;
			x += round_mix(y, s, key_words[0], key_words[1]);
			y += round_mix(x, s, key_words[2], key_words[3]);
		end
		return {y, x};
	endfunction

	function automatic tea_block_t tea_decipher(input tea_block_t blk);
		logic [WORD_W-1:0] x, y, s;
		x = blk.first;
		y = blk.second;
		s = TEA_DELTA * ROUND_COUNT;
		for (int r = 0; r < ROUND_COUNT; r++) begin
			y -= round_mix(x, s, key_words[2], key_words[3]);
			x -= round_mix(y, s, key_words[0], key_words[1]);
			s -= TEA_DELTA;
		end
		return {y, x};
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [BLOCK_W-1:0] data);
		case (idx) inside
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_words[idx[1:0]] = data[WORD_W-1:0];
			REG_IV:      init_vec = data;
			REG_MODE:    chain_sel = data[1:0];
			REG_DECRYPT: decrypt_on = data[0];
			default: ;
		endcase
	endfunction

	// Works out the output block for one input block and advances the chaining state.
	function automatic tea_block_t predict_block(input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic start);
		tea_block_t din, res, stream;
		din = {w1, w0};
		if (start) begin
			chain_block = init_vec;
			block_index = '0;
		end
		case (chain_sel)
			MODE_CTR: begin
				stream = tea_encipher({init_vec[63:32] + block_index[31:0],
					init_vec[31:0] + block_index[63:32]});
				res = din ^ stream;
			end
			MODE_CBC: begin
				if (decrypt_on) begin
					res = tea_decipher(din) ^ chain_block;
					chain_block = din;
				end else begin
					res = tea_encipher(din ^ chain_block);
					chain_block = res;
				end
			end
			default: res = decrypt_on ? tea_decipher(din) : tea_encipher(din);
		endcase
		block_index += BLOCK_W'(1);
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Model update and result checking, all on values sampled at the clock edge
	always @(posedge clk) begin : check_results
		tea_block_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				apply_register(cfg_bus.index, cfg_bus.data);
			if (out_bus.valid && out_bus.ready) begin
				if (expected_blocks.size() == 0) begin
					$error("result with nothing expected: %h %h",
						out_bus.result_first, out_bus.result_second);
					fail_count++;
				end else begin
					want = expected_blocks.pop_front();
					if (out_bus.result_first !== want.first) begin
						$error("result_first: expected %h, actual %h", want.first,
							out_bus.result_first);
						fail_count++;
					end
					if (out_bus.result_second !== want.second) begin
						$error("result_second: expected %h, actual %h", want.second,
							out_bus.result_second);
						fail_count++;
					end
				end
			end
			if (in_bus.valid && in_bus.ready)
				expected_blocks.push_back(predict_block(in_bus.word_first,
					in_bus.word_second, in_bus.message_start));
		end
	end

	always @(posedge clk) begin
		out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_bus.valid && cfg_bus.ready) || (in_bus.valid && in_bus.ready) ||
					(out_bus.valid && out_bus.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL tea_cipher_ecb_cbc_ctr_unit");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	task automatic send_block(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
			input logic start);
		cfg_bus.valid <= 1'b0;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_bus.valid         <= 1'b1;
		in_bus.word_first    <= w0;
		in_bus.word_second   <= w1;
		in_bus.message_start <= start;
		do @(posedge clk); while (!in_bus.ready);
	endtask

	// Returns once every expected block has arrived and the engine has settled.
	task automatic wait_idle();
		in_bus.valid  <= 1'b0;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		write_reg(REG_KEY0, {$urandom, k0});
		write_reg(REG_KEY1, {$urandom, k1});
		write_reg(REG_KEY2, {$urandom, k2});
		write_reg(REG_KEY3, {$urandom, k3});
	endtask

	// Runs from the reset settings; the first blocks carry no message start.
	task automatic test_ecb_directed();
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b0);
		send_block('0, '1, 1'b1);
		wait_idle();
		write_keys('1, '1, '1, '1);
		write_reg(REG_DECRYPT, {{(BLOCK_W-1){1'b1}}, 1'b1});
		send_block('1, '0, 1'b1);
		send_block('0, '0, 1'b0);
	endtask

	task automatic test_cbc_directed();
		wait_idle();
		write_keys(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
		write_reg(REG_IV, '1);
		write_reg(REG_MODE, {{(BLOCK_W-2){1'b0}}, MODE_CBC});
		write_reg(REG_DECRYPT, '0);
		send_block(32'hdead_beef, 32'h0bad_f00d, 1'b1);
		send_block('1, '1, 1'b0);
		send_block('0, '0, 1'b0);
		wait_idle();
		write_reg(REG_DECRYPT, 64'd1);
		send_block(32'h1234_5678, 32'h9abc_def0, 1'b1);
		send_block('1, '0, 1'b0);
		// A message start in the middle of a stream reloads the chain from the IV.
		send_block('0, '1, 1'b1);
		send_block(32'h5555_aaaa, 32'haaaa_5555, 1'b0);
	endtask

	task automatic test_ctr_directed();
		wait_idle();
		// An all-ones IV makes the counter addition wrap from the second block on.
		write_reg(REG_MODE, {{(BLOCK_W-2){1'b1}}, MODE_CTR});
		write_reg(REG_DECRYPT, '0);
		send_block('0, '0, 1'b1);
		send_block('1, '1, 1'b0);
		send_block(32'hcafe_babe, 32'h0000_0001, 1'b0);
		wait_idle();
		// The direction bit has no effect in counter mode.
		write_reg(REG_DECRYPT, 64'd1);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_block('1, '0, 1'b0);
		send_block('0, '1, 1'b1);
		wait_idle();
		// The spare mode code falls back to plain block mode.
		write_reg(REG_MODE, {{(BLOCK_W-2){1'b0}}, MODE_SPARE});
		send_block(32'h8000_0000, 32'h0000_0001, 1'b1);
		wait_idle();
		write_reg(REG_DECRYPT, '0);
		send_block(32'h0000_0001, 32'h8000_0000, 1'b0);
	endtask

	task automatic randomize_settings();
		logic [BLOCK_W-1:0] mode_data;
		mode_data = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2: mode_data[1:0] = MODE_ECB;
			3, 4, 5: mode_data[1:0] = MODE_CBC;
			6, 7, 8: mode_data[1:0] = MODE_CTR;
			default: mode_data[1:0] = MODE_SPARE;
		endcase
		write_keys(rand_word(), rand_word(), rand_word(), rand_word());
		write_reg(REG_IV, {rand_word(), rand_word()});
		write_reg(REG_MODE, mode_data);
		write_reg(REG_DECRYPT, {$urandom, $urandom});
	endtask

	// Messages of random length under a fresh setting each time the unit is idle.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned sent;
		int unsigned seg_len;
		sent = 0;
		while (sent < count) begin
			wait_idle();
			randomize_settings();
			seg_len = $urandom_range(10, 60);
			for (int unsigned i = 0; i < seg_len && sent < count; i++) begin
				send_block(rand_word(), rand_word(),
					(i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(11) == 0));
				sent++;
			end
		end
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		fail_count           = 0;
		stall_cycles         = 0;
		tx_idle_pct          = 14;
		rx_idle_pct          = 75;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = '0;
		cfg_bus.data         = '0;
		in_bus.valid         = 1'b0;
		in_bus.word_first    = '0;
		in_bus.word_second   = '0;
		in_bus.message_start = 1'b0;
		out_bus.ready        = 1'b0;
		for (int i = 0; i < 4; i++)
			key_words[i] = '0;
		init_vec    = '0;
		chain_sel   = MODE_ECB;
		decrypt_on  = 1'b0;
		chain_block = '0;
		block_index = '0;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		test_ecb_directed();
		test_cbc_directed();
		test_ctr_directed();
		test_random_traffic(260);
		tx_idle_pct = 75;
		rx_idle_pct = 14;
		test_random_traffic(260);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(260);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_blocks.size() != 0) begin
			$error("%0d result blocks never arrived", expected_blocks.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS tea_cipher_ecb_cbc_ctr_unit");
		else
			$display("FAIL tea_cipher_ecb_cbc_ctr_unit");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tea_pkg.sv
sv/tea_if.sv
sv/tea_front.sv
sv/tea_queue.sv
sv/tea_back.sv
sv/tea_cipher_ecb_cbc_ctr_unit.sv
test/tb_tea_cipher_ecb_cbc_ctr_unit.sv
